/* hdl/tlbrf_pkg.sv */
`timescale 1ns / 1ps

package tlbrf_pkg;

  // Fixed field widths of the stream words
  localparam int FUNC_W  = 2;
  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 20;
  localparam int SLOT_W  = 4;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 5;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 32;

  // Build defaults
  localparam int TLB_DEPTH_DEF = 16;
  localparam int PAGE_BITS_DEF = 20;

  // Operation codes carried in s_tuser
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_POLICY  = 1'b0;
  localparam logic CFG_ENTRIES = 1'b1;

  // Replacement policy codes
  localparam logic POLICY_LRU  = 1'b0;
  localparam logic POLICY_FIFO = 1'b1;

  localparam logic [CNT_W-1:0]   ENTRIES_RESET = 5'd16;
  localparam logic [STAMP_W-1:0] STAMP_MAX     = 32'hFFFF_FFFF;

  // Result of the shared compare unit for one entry
  typedef struct packed {
    logic match;   // stored page equals key
    logic less;    // entry stamp below best so far
  } scan_res_t;

  // Saturating stamp increment
  function automatic logic [STAMP_W-1:0] bump(input logic [STAMP_W-1:0] c);
    bump = (c == STAMP_MAX) ? c : c + STAMP_W'(1);
  endfunction

endpackage

/* hdl/tlb_lru_fifo_replacement_core.sv */
`timescale 1ns / 1ps

// Fully associative translation buffer, LRU or FIFO replacement.
// Input words arrive on s_tvalid/s_tready: s_tuser holds the operation
// (lookup, insert, flush), s_tdata the page and frame. One result word per
// input leaves on m_tvalid/m_tready: hit flag, frame found and slot.
// Configuration words (policy, active entry count) arrive on cfg_valid /
// cfg_ready, which is always ready; write only while the buffer is idle.
// A lookup or insert walks the active entries one per cycle through the
// entry RAM and the shared compare unit, the RAM read port setting the
// pace. Flush and unknown codes skip the walk. The result is registered
// once the output register is free, and s_tready returns together with
// it. s_tready is high only while no item is in progress.
// The result sits in an output register; if the receiver stalls, the next
// item may still be taken and run, and it waits before its own result
// until the register is free.
// Reset (rst, synchronous) invalidates all entries, clears both stamp
// counters and sets policy to LRU and the active count to 16.
module tlb_lru_fifo_replacement_core #(
  parameter int TLB_DEPTH = tlbrf_pkg::TLB_DEPTH_DEF,
  parameter int PAGE_BITS = tlbrf_pkg::PAGE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input words
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tlbrf_pkg::S_TDATA_W-1:0]   s_tdata,   // page[19:0], frame[39:20]
  input  logic [tlbrf_pkg::FUNC_W-1:0]      s_tuser,   // func[1:0]
  // result words
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tlbrf_pkg::M_TDATA_W-1:0]   m_tdata,   // hit[0], frame_found[20:1], slot[24:21]
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [tlbrf_pkg::CNT_W-1:0]       cfg_data
);

  localparam int IDX_W  = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam int SW     = tlbrf_pkg::STAMP_W;
  localparam int FW     = tlbrf_pkg::FRAME_W;
  localparam int WORD_W = PAGE_BITS + FW + 2 * SW;
  // entry word layout, low to high: fill stamp, use stamp, frame, page
  localparam int USE_LO  = SW;
  localparam int FRM_LO  = 2 * SW;
  localparam int PAGE_LO = 2 * SW + FW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  // configuration
  logic                        policy;
  logic [tlbrf_pkg::CNT_W-1:0] entries_in_use;

  // held item
  logic [tlbrf_pkg::FUNC_W-1:0] func;
  logic [PAGE_BITS-1:0]         key_page;
  logic [FW-1:0]                in_frame;
  logic [IDX_W-1:0]             last_idx;

  // walk control
  logic             rd_more;
  logic [IDX_W-1:0] rd_idx;
  logic             eval_vld;
  logic [IDX_W-1:0] eval_idx;

  // search results
  logic             inv_found;
  logic [IDX_W-1:0] inv_idx;
  logic [IDX_W-1:0] best_idx;
  logic [SW-1:0]    best_stamp;
  logic [IDX_W-1:0] hit_idx;
  logic [FW-1:0]    hit_frame;
  logic [SW-1:0]    hit_fill;

  logic [TLB_DEPTH-1:0] valid;
  logic [SW-1:0]        use_counter;
  logic [SW-1:0]        fill_counter;

  // pending result
  logic                            res_hit;
  logic [FW-1:0]                   res_frame;
  logic [tlbrf_pkg::SLOT_W-1:0]    res_slot;

  // RAM port signals
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [WORD_W-1:0] rd_data;

  logic [SW-1:0]        entry_stamp;
  logic [IDX_W-1:0]     victim;
  logic [IDX_W-1:0]     last_calc;
  logic [SW-1:0]        use_bumped;
  logic [SW-1:0]        fill_bumped;
  tlbrf_pkg::scan_res_t scan;
  logic                 in_take;
  logic                 out_free;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // active count clamped to 1..TLB_DEPTH, kept as last index
  always_comb begin
    if (entries_in_use == '0) begin
      last_calc = '0;
    end else if (32'(entries_in_use) > 32'(TLB_DEPTH)) begin
      last_calc = IDX_W'(TLB_DEPTH - 1);
    end else begin
      last_calc = IDX_W'(entries_in_use - tlbrf_pkg::CNT_W'(1));
    end
  end

  // entry store and shared compare unit
  tlbrf_ram #(.WIDTH(WORD_W), .DEPTH(TLB_DEPTH), .AW(IDX_W)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  assign entry_stamp = (policy == tlbrf_pkg::POLICY_FIFO) ? rd_data[SW-1:0]
                                                          : rd_data[USE_LO +: SW];

  tlbrf_scan #(.PAGE_BITS(PAGE_BITS)) u_scan (
    .key_page    (key_page),
    .entry_page  (rd_data[PAGE_LO +: PAGE_BITS]),
    .entry_stamp (entry_stamp),
    .best_stamp  (best_stamp),
    .res         (scan)
  );

  // write-back of a hit refresh or an insert
  assign use_bumped  = tlbrf_pkg::bump(use_counter);
  assign fill_bumped = tlbrf_pkg::bump(fill_counter);
  assign victim      = inv_found ? inv_idx : best_idx;
  assign wr_en       = (state == ST_WRITE);

  always_comb begin
    if (func == tlbrf_pkg::FUNC_INSERT) begin
      wr_addr = victim;
      wr_data = {key_page, in_frame, use_bumped, fill_bumped};
    end else begin
      wr_addr = hit_idx;
      wr_data = {key_page, hit_frame, use_bumped, hit_fill};
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          if (s_tuser == tlbrf_pkg::FUNC_LOOKUP || s_tuser == tlbrf_pkg::FUNC_INSERT) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (eval_vld) begin
          if (func == tlbrf_pkg::FUNC_LOOKUP && valid[eval_idx] && scan.match) begin
            state_next = ST_WRITE;
          end else if (eval_idx == last_idx) begin
            state_next = (func == tlbrf_pkg::FUNC_INSERT) ? ST_WRITE : ST_DONE;
          end
        end
      end
      ST_WRITE: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      policy         <= tlbrf_pkg::POLICY_LRU;
      entries_in_use <= tlbrf_pkg::ENTRIES_RESET;
      valid          <= '0;
      use_counter    <= '0;
      fill_counter   <= '0;
      rd_more        <= 1'b0;
      eval_vld       <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;

      // configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tlbrf_pkg::CFG_POLICY:  policy         <= cfg_data[0];
          tlbrf_pkg::CFG_ENTRIES: entries_in_use <= cfg_data;
          default: ;
        endcase
      end

      // item accept
      if (in_take) begin
        func      <= s_tuser;
        key_page  <= PAGE_BITS'(s_tdata[tlbrf_pkg::PAGE_W-1:0]);
        in_frame  <= s_tdata[tlbrf_pkg::PAGE_W +: FW];
        last_idx  <= last_calc;
        rd_idx    <= '0;
        rd_more   <= 1'b1;
        eval_vld  <= 1'b0;
        inv_found <= 1'b0;
        res_hit   <= 1'b0;
        res_frame <= '0;
        res_slot  <= '0;
        if (s_tuser == tlbrf_pkg::FUNC_FLUSH) begin
          valid        <= '0;
          use_counter  <= '0;
          fill_counter <= '0;
        end
      end

      // walk: issue one read and evaluate the previous one each cycle
      if (state == ST_SCAN) begin
        if (rd_more) begin
          rd_idx  <= rd_idx + IDX_W'(1);
          rd_more <= (rd_idx != last_idx);
        end
        eval_vld <= rd_more;
        eval_idx <= rd_idx;
        if (eval_vld) begin
          if (func == tlbrf_pkg::FUNC_LOOKUP) begin
            if (valid[eval_idx] && scan.match) begin
              hit_idx   <= eval_idx;
              hit_frame <= rd_data[FRM_LO +: FW];
              hit_fill  <= rd_data[SW-1:0];
            end
          end else begin
            if (!valid[eval_idx] && !inv_found) begin
              inv_found <= 1'b1;
              inv_idx   <= eval_idx;
            end
            if (eval_idx == '0 || scan.less) begin
              best_idx   <= eval_idx;
              best_stamp <= entry_stamp;
            end
          end
        end
      end

      // write-back: stamps, valid bit, result
      if (state == ST_WRITE) begin
        use_counter <= use_bumped;
        res_slot    <= tlbrf_pkg::SLOT_W'(wr_addr);
        if (func == tlbrf_pkg::FUNC_INSERT) begin
          fill_counter    <= fill_bumped;
          valid[wr_addr]  <= 1'b1;
        end else begin
          res_hit   <= 1'b1;
          res_frame <= hit_frame;
        end
      end

      // output register
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {7'b0, res_slot, res_frame, res_hit};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_eval_in_range: assert property (@(posedge clk) disable iff (rst)
    eval_vld |-> eval_idx <= last_idx)
    else $error("walk evaluated an entry beyond the active count");

  a_insert_sets_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en && func == tlbrf_pkg::FUNC_INSERT |=> valid[$past(wr_addr)])
    else $error("inserted entry not marked valid");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !s_tready)
    else $error("ready again directly after taking a word");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_DONE))
    else $error("result presented outside the done step");
`endif

endmodule

/* hdl/tlbrf_ram.sv */
`timescale 1ns / 1ps

module tlbrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/tlbrf_scan.sv */
`timescale 1ns / 1ps

module tlbrf_scan #(
  parameter int PAGE_BITS = tlbrf_pkg::PAGE_BITS_DEF
) (
  input  logic [PAGE_BITS-1:0]          key_page,
  input  logic [PAGE_BITS-1:0]          entry_page,
  input  logic [tlbrf_pkg::STAMP_W-1:0] entry_stamp,
  input  logic [tlbrf_pkg::STAMP_W-1:0] best_stamp,
  output tlbrf_pkg::scan_res_t          res
);

  // shared compare: page equality and stamp ordering for the entry in hand
  always_comb begin
    res.match = (entry_page == key_page);
    res.less  = (entry_stamp < best_stamp);
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int DEPTH      = tlbrf_pkg::TLB_DEPTH_DEF;
  localparam int WATCHDOG   = 4000;
  localparam int HOLD_OFF   = 400;
  localparam int TAIL_WAIT  = 40;
  localparam int MAX_REPORT = 40;
  localparam int PHASES     = 12;
  localparam int PHASE_REQS = 120;

  // func 3 has no name in the package: the block must ignore it
  localparam logic [tlbrf_pkg::FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [tlbrf_pkg::FUNC_W-1:0]  func;
    logic [tlbrf_pkg::PAGE_W-1:0]  page;
    logic [tlbrf_pkg::FRAME_W-1:0] frame;
  } req_t;

  typedef struct packed {
    logic                          hit;
    logic [tlbrf_pkg::FRAME_W-1:0] frame_found;
    logic [tlbrf_pkg::SLOT_W-1:0]  slot;
  } xlat_t;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  logic                            s_tready;
  logic [tlbrf_pkg::S_TDATA_W-1:0] s_tdata   = '0;   // page[19:0], frame[39:20]
  logic [tlbrf_pkg::FUNC_W-1:0]    s_tuser   = '0;   // func[1:0]
  logic                            m_tvalid;
  logic                            m_tready  = 1'b0;
  logic [tlbrf_pkg::M_TDATA_W-1:0] m_tdata;          // hit[0], frame_found[20:1], slot[24:21]
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_index = 1'b0;
  logic [tlbrf_pkg::CNT_W-1:0]     cfg_data  = '0;

  tlb_lru_fifo_replacement_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the translation buffer
  logic                          tlb_valid      [DEPTH];
  logic [tlbrf_pkg::PAGE_W-1:0]  tlb_page       [DEPTH];
  logic [tlbrf_pkg::FRAME_W-1:0] tlb_frame      [DEPTH];
  logic [tlbrf_pkg::STAMP_W-1:0] tlb_use_stamp  [DEPTH];
  logic [tlbrf_pkg::STAMP_W-1:0] tlb_fill_stamp [DEPTH];
  logic [tlbrf_pkg::STAMP_W-1:0] use_clock;
  logic [tlbrf_pkg::STAMP_W-1:0] fill_clock;
  logic                          cur_policy;
  logic [tlbrf_pkg::CNT_W-1:0]   cur_entries;

  req_t  req_queue [$];
  xlat_t expected_xlat [$];
  req_t  cur_req;
  xlat_t want;

  int err_cnt      = 0;
  int send_gap     = 0;
  int recv_gap     = 0;
  int hold_cnt     = 0;
  int hold_request = 0;
  bit hold_done    = 1'b0;
  int quiet_cycles = 0;
  bit no_idle      = 1'b0;

  function automatic logic [tlbrf_pkg::STAMP_W-1:0] sat_inc(
      input logic [tlbrf_pkg::STAMP_W-1:0] c);
    return (c == '1) ? c : c + tlbrf_pkg::STAMP_W'(1);
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60)
      return 0;
    if (r < 94)
      return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Work out the result of one request and update the shadow buffer
  function automatic xlat_t translate(input req_t r);
    xlat_t                         res;
    int                            n, i, victim;
    logic                          found;
    logic [tlbrf_pkg::STAMP_W-1:0] best, s;
    res = '0;
    n = int'(cur_entries);
    if (n == 0)
      n = 1;
    if (n > DEPTH)
      n = DEPTH;
    case (r.func)
      tlbrf_pkg::FUNC_LOOKUP: begin
        found = 1'b0;
        for (i = 0; i < n; i++)
          if (!found && tlb_valid[i] && tlb_page[i] == r.page) begin
            found            = 1'b1;
            use_clock        = sat_inc(use_clock);
            tlb_use_stamp[i] = use_clock;
            res.hit          = 1'b1;
            res.frame_found  = tlb_frame[i];
            res.slot         = i[tlbrf_pkg::SLOT_W-1:0];
          end
      end
      tlbrf_pkg::FUNC_INSERT: begin
        // a free entry first, otherwise the oldest stamp, lowest index on a tie
        victim = -1;
        for (i = 0; i < n; i++)
          if (victim < 0 && !tlb_valid[i])
            victim = i;
        if (victim < 0) begin
          victim = 0;
          best   = (cur_policy == tlbrf_pkg::POLICY_FIFO) ? tlb_fill_stamp[0]
                                                          : tlb_use_stamp[0];
          for (i = 1; i < n; i++) begin
            s = (cur_policy == tlbrf_pkg::POLICY_FIFO) ? tlb_fill_stamp[i]
                                                       : tlb_use_stamp[i];
            if (s < best) begin
              best   = s;
              victim = i;
            end
          end
        end
        tlb_valid[victim]      = 1'b1;
        tlb_page[victim]       = r.page;
        tlb_frame[victim]      = r.frame;
        use_clock              = sat_inc(use_clock);
        tlb_use_stamp[victim]  = use_clock;
        fill_clock             = sat_inc(fill_clock);
        tlb_fill_stamp[victim] = fill_clock;
        res.slot               = victim[tlbrf_pkg::SLOT_W-1:0];
      end
      tlbrf_pkg::FUNC_FLUSH: begin
        // every built entry, not only the active ones
        for (i = 0; i < DEPTH; i++)
          tlb_valid[i] = 1'b0;
        use_clock  = '0;
        fill_clock = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic push_req(input logic [tlbrf_pkg::FUNC_W-1:0] f,
                          input logic [tlbrf_pkg::PAGE_W-1:0] p,
                          input logic [tlbrf_pkg::FRAME_W-1:0] fr);
    req_t r;
    r.func  = f;
    r.page  = p;
    r.frame = fr;
    req_queue.push_back(r);
  endtask

  // Register write; the shadow copy follows at the handshake
  task automatic write_reg(input logic idx, input logic [tlbrf_pkg::CNT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == tlbrf_pkg::CFG_POLICY)
      cur_policy = val[0];
    else
      cur_entries = val;
    cfg_valid <= 1'b0;
  endtask

  // Idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (req_queue.size() != 0 || s_tvalid || expected_xlat.size() != 0);
  endtask

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORT)
        $display("%0t: %s expected %0h got %0h", $time, name, exp_val, got_val);
    end
  endtask

  // Request driver; the shadow buffer is cleared with the block
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
      foreach (tlb_valid[k]) begin
        tlb_valid[k]      = 1'b0;
        tlb_page[k]       = '0;
        tlb_frame[k]      = '0;
        tlb_use_stamp[k]  = '0;
        tlb_fill_stamp[k] = '0;
      end
      use_clock  = '0;
      fill_clock = '0;
    end else begin
      // word taken at this edge
      if (s_tvalid && s_tready)
        expected_xlat.push_back(translate(cur_req));
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          cur_req = req_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {cur_req.frame, cur_req.page};
          s_tuser  <= cur_req.func;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_xlat.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORT)
            $display("%0t: result expected none got %0h", $time, m_tdata);
        end else begin
          want = expected_xlat.pop_front();
          check_field("hit", int'(want.hit), int'(m_tdata[0]));
          check_field("frame_found", int'(want.frame_found), int'(m_tdata[20:1]));
          check_field("slot", int'(want.slot), int'(m_tdata[24:21]));
        end
      end
      if (hold_request > 0 && !hold_done) begin
        hold_cnt  = hold_request;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Watchdog on words moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int                           ph, k, pool_n, r;
    logic                         pol;
    logic [tlbrf_pkg::CNT_W-1:0]  ents;
    logic [tlbrf_pkg::PAGE_W-1:0] pool [$];
    logic [tlbrf_pkg::PAGE_W-1:0] pg;

    cur_policy  = tlbrf_pkg::POLICY_LRU;
    cur_entries = tlbrf_pkg::ENTRIES_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty miss, field extremes, duplicate page, unknown op, flush
    push_req(tlbrf_pkg::FUNC_LOOKUP, 20'h00000, 20'h00000);
    push_req(tlbrf_pkg::FUNC_INSERT, 20'h00000, 20'h00000);
    push_req(tlbrf_pkg::FUNC_INSERT, 20'hFFFFF, 20'hFFFFF);
    push_req(tlbrf_pkg::FUNC_LOOKUP, 20'hFFFFF, 20'h00000);
    push_req(tlbrf_pkg::FUNC_LOOKUP, 20'h00000, 20'hFFFFF);
    push_req(tlbrf_pkg::FUNC_INSERT, 20'hFFFFF, 20'h5A5A5);
    push_req(tlbrf_pkg::FUNC_LOOKUP, 20'hFFFFF, 20'hA5A5A);
    push_req(FUNC_UNKNOWN,           20'hFFFFF, 20'hFFFFF);
    push_req(tlbrf_pkg::FUNC_FLUSH,  20'hFFFFF, 20'hFFFFF);
    push_req(tlbrf_pkg::FUNC_LOOKUP, 20'hFFFFF, 20'h00000);
    wait_idle();

    // FIFO over two entries: a hit must not save the oldest fill
    write_reg(tlbrf_pkg::CFG_ENTRIES, 5'd2);
    write_reg(tlbrf_pkg::CFG_POLICY, {4'b0, tlbrf_pkg::POLICY_FIFO});
    push_req(tlbrf_pkg::FUNC_INSERT, 20'h12345, 20'hAAAAA);
    push_req(tlbrf_pkg::FUNC_INSERT, 20'h54321, 20'h55555);
    push_req(tlbrf_pkg::FUNC_LOOKUP, 20'h12345, 20'h00000);
    push_req(tlbrf_pkg::FUNC_INSERT, 20'h0ABCD, 20'h11111);
    push_req(tlbrf_pkg::FUNC_LOOKUP, 20'h12345, 20'h00000);
    wait_idle();

    // LRU: the hit entry survives
    write_reg(tlbrf_pkg::CFG_POLICY, {4'b0, tlbrf_pkg::POLICY_LRU});
    push_req(tlbrf_pkg::FUNC_LOOKUP, 20'h0ABCD, 20'h00000);
    push_req(tlbrf_pkg::FUNC_INSERT, 20'h33333, 20'h22222);
    wait_idle();

    // zero active entries acts as one; slot 1 goes out of reach
    write_reg(tlbrf_pkg::CFG_ENTRIES, 5'd0);
    push_req(tlbrf_pkg::FUNC_INSERT, 20'h77777, 20'h66666);
    push_req(tlbrf_pkg::FUNC_LOOKUP, 20'h33333, 20'h00000);
    wait_idle();

    // above the built depth acts as full; hidden entries kept their contents
    write_reg(tlbrf_pkg::CFG_ENTRIES, 5'd31);
    push_req(tlbrf_pkg::FUNC_LOOKUP, 20'h33333, 20'h00000);
    push_req(tlbrf_pkg::FUNC_INSERT, 20'h44444, 20'h88888);
    push_req(tlbrf_pkg::FUNC_FLUSH,  20'h00000, 20'h00000);

    // Random phases, each with its own page pool so lookups hit
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      no_idle = ($urandom_range(0, 3) == 0) && (ph != 4);
      pol     = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
      case (ph)
        0, 6, 11: ents = 5'd16;
        1:        ents = 5'd1;
        2:        ents = 5'd0;
        3:        ents = 5'd31;
        4:        ents = 5'd17;
        5:        ents = 5'd2;
        7:        ents = 5'd4;
        8:        ents = 5'd8;
        9:        ents = 5'd3;
        default:  ents = 5'($urandom_range(0, 31));
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(tlbrf_pkg::CFG_POLICY, {4'b0, pol});
        write_reg(tlbrf_pkg::CFG_ENTRIES, ents);
      end else begin
        write_reg(tlbrf_pkg::CFG_ENTRIES, ents);
        write_reg(tlbrf_pkg::CFG_POLICY, {4'b0, pol});
      end

      pool.delete();
      pool_n = $urandom_range(3, 24);
      repeat (pool_n) pool.push_back(20'($urandom));

      for (k = 0; k < PHASE_REQS; k++) begin
        r  = $urandom_range(0, 99);
        pg = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, pool_n - 1)]
                                          : 20'($urandom);
        if (r < 1)
          push_req(tlbrf_pkg::FUNC_FLUSH, pg, 20'($urandom));
        else if (r < 3)
          push_req(FUNC_UNKNOWN, pg, 20'($urandom));
        else if (r < 40)
          push_req(tlbrf_pkg::FUNC_INSERT, pg, 20'($urandom));
        else
          push_req(tlbrf_pkg::FUNC_LOOKUP, pg, 20'($urandom));
      end

      // long receiver hold-off while requests keep coming
      if (ph == 4)
        hold_request = HOLD_OFF;
    end

    wait_idle();
    repeat (TAIL_WAIT) @(posedge clk);
    if (err_cnt == 0 && expected_xlat.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
